@@ src/assert_macros.svh @@
// Shared assertion helpers. Clocked on the rising edge, idle while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define CISC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define CISC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) ante |=> cons) else $error(msg);

`endif

@@ src/cisc_pkg.sv @@
`timescale 1ns / 1ps

package cisc_pkg;

  localparam int CISC_MAX_NEST = 64;

  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;
  localparam int NEST_W   = 7;
  localparam int CNT_W    = 64;

  localparam logic [STATUS_W-1:0] ST_MORE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_DEEP  = 3'd4;

  typedef struct packed {
    logic load;
    logic eval;
    logic step;
  } cisc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cascade;
  } cisc_stat_t;

endpackage

@@ src/cisc_in_if.sv @@
`timescale 1ns / 1ps

interface cisc_in_if import cisc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ src/cisc_out_if.sv @@
`timescale 1ns / 1ps

interface cisc_out_if import cisc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NEST_W-1:0]   nesting_level;

  modport source (output valid, output status, output nesting_level, input ready);
  modport sink (input valid, input status, input nesting_level, output ready);
endinterface

@@ src/cbor_item_skip_checker_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Payload                              Handshake
// bytes     in   data_byte[7:0], last_byte            valid/ready
// result    out  status[2:0], nesting_level[6:0]      valid/ready
//
// Each byte is accepted, then evaluated when the result slot is free; no new byte is taken meanwhile.
// Each container closed by the same byte adds a stack memory read in the pop state,
// except one whose close leaves no container open.
// Evaluation waits while the previous result has not been taken.
// Reset is synchronous; ready is registered and rises in the cycle after reset drops. The stack memory is not cleared.

module cbor_item_skip_checker_core import cisc_pkg::*; #(
  parameter int MAX_NEST = CISC_MAX_NEST
) (
  input  logic       clk,
  input  logic       rst,
  cisc_in_if.sink    bytes,
  cisc_out_if.source result
);

  cisc_cmd_t  cmd;
  cisc_stat_t st;
  logic       byte_ready;

  assign bytes.ready = byte_ready;

  cisc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (bytes.valid),
    .byte_ready (byte_ready),
    .cmd        (cmd),
    .st         (st)
  );

  cisc_dp #(
    .MAX_NEST (MAX_NEST)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (bytes.data_byte),
    .last_byte (bytes.last_byte),
    .cmd       (cmd),
    .st        (st),
    .result    (result)
  );

endmodule

@@ src/cisc_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cisc_ctrl import cisc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  output cisc_cmd_t  cmd,
  input  cisc_stat_t st
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_POP} state_t;

  state_t state, state_next;

  always_comb begin
    cmd.load = byte_valid && byte_ready;
    cmd.eval = (state == S_EVAL) && st.out_free;
    cmd.step = (state == S_POP);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (cmd.eval) state_next = st.cascade ? S_POP : S_IDLE;
      end
      S_POP: begin
        state_next = st.cascade ? S_POP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_ready <= 1'b0;
    end else begin
      state      <= state_next;
      byte_ready <= (state_next == S_IDLE);
    end
  end

  // result slot stays free through a pop cascade
  `CISC_ASSERT(a_pop_out_free, clk, rst, state == S_POP |-> st.out_free, "pop with result pending")
  `CISC_ASSERT(a_ready_idle, clk, rst, byte_ready |-> state == S_IDLE, "ready outside idle")
  `CISC_ASSERT_NEXT(a_load_eval, clk, rst, cmd.load, state == S_EVAL, "accepted byte not evaluated")

endmodule

@@ src/cisc_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cisc_dp import cisc_pkg::*; #(
  parameter int MAX_NEST = CISC_MAX_NEST
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              last_byte,
  input  cisc_cmd_t         cmd,
  output cisc_stat_t        st,
  cisc_out_if.source        result
);

  localparam int STACK_SIZE = MAX_NEST + 1;
  localparam int LVL_W      = $clog2(MAX_NEST + 2);
  localparam int ADDR_W     = (STACK_SIZE > 1) ? $clog2(STACK_SIZE) : 1;

  localparam logic [2:0] MT_BSTR  = 3'd2;
  localparam logic [2:0] MT_TSTR  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;
  localparam logic [2:0] MT_TAG   = 3'd6;

  localparam logic [4:0] AI_ARG1   = 5'd24;
  localparam logic [4:0] AI_RSV_LO = 5'd28;
  localparam logic [4:0] AI_RSV_HI = 5'd31;

  typedef enum logic [1:0] {PH_HEAD, PH_ARG, PH_PAYLOAD} phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             pend_value;
    logic             is_map;
  } entry_t;

  logic [DATA_W-1:0] byte_r;
  logic              last_r;

  phase_t            phase, phase_next;
  logic [2:0]        head_major, head_major_next;
  logic [3:0]        arg_left, arg_left_next, arg_dec;
  logic [CNT_W-1:0]  arg_value, arg_value_next;
  logic [CNT_W-1:0]  payload_left, payload_left_next, payload_dec;
  logic [LVL_W-1:0]  open_levels, open_levels_next, lvl_dec, nest_val;
  logic [CNT_W-1:0]  top_cnt, top_cnt_next, cnt_dec;
  logic              top_pend, top_pend_next;
  logic              top_map, top_map_next;

  entry_t            mem [STACK_SIZE];
  entry_t            rd_entry, wr_entry, fin_src;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;

  logic              hd_req, fin_req, cascade, emit;
  logic [CNT_W-1:0]  hd_val;
  logic [STATUS_W-1:0] code, final_code;
  logic [2:0]        major;
  logic [4:0]        ai;

  assign major = byte_r[7:5];
  assign ai    = byte_r[4:0];

  always_comb begin
    phase_next        = phase;
    head_major_next   = head_major;
    arg_left_next     = arg_left;
    arg_value_next    = arg_value;
    payload_left_next = payload_left;
    open_levels_next  = open_levels;
    top_cnt_next      = top_cnt;
    top_pend_next     = top_pend;
    top_map_next      = top_map;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = ADDR_W'(open_levels - LVL_W'(1));
    wr_entry = '{cnt: top_cnt, pend_value: top_pend, is_map: top_map};
    raddr    = '0;
    hd_req   = 1'b0;
    hd_val   = '0;
    fin_req  = 1'b0;
    cascade  = 1'b0;
    code     = ST_MORE;
    arg_dec     = '0;
    payload_dec = '0;
    cnt_dec     = '0;
    lvl_dec     = '0;
    fin_src  = cmd.step ? rd_entry
                        : '{cnt: top_cnt, pend_value: top_pend, is_map: top_map};

    if (cmd.eval) begin
      case (phase)
        PH_ARG: begin
          arg_value_next = {arg_value[CNT_W-DATA_W-1:0], byte_r};
          arg_dec        = (arg_left != '0) ? arg_left - 4'd1 : '0;
          arg_left_next  = arg_dec;
          if (arg_dec == '0) begin
            phase_next = PH_HEAD;
            hd_req     = 1'b1;
            hd_val     = arg_value_next;
          end
        end
        PH_PAYLOAD: begin
          payload_dec       = (payload_left != '0) ? payload_left - CNT_W'(1) : '0;
          payload_left_next = payload_dec;
          if (payload_dec == '0) begin
            phase_next = PH_HEAD;
            fin_req    = 1'b1;
          end
        end
        default: begin
          phase_next = PH_HEAD;
          if (open_levels > LVL_W'(MAX_NEST)) begin
            code = ST_TOO_DEEP;
          end else if ((ai inside {[AI_RSV_LO:AI_RSV_HI]}) || major == MT_TAG) begin
            code = ST_MALFORMED;
          end else begin
            head_major_next = major;
            if (ai < AI_ARG1) begin
              hd_req = 1'b1;
              hd_val = CNT_W'(ai);
            end else begin
              arg_left_next  = 4'd1 << ai[1:0];
              arg_value_next = '0;
              phase_next     = PH_ARG;
            end
          end
        end
      endcase
    end

    // head fully decoded
    if (hd_req) begin
      case (head_major_next)
        MT_BSTR, MT_TSTR: begin
          if (hd_val == '0) begin
            fin_req = 1'b1;
          end else begin
            payload_left_next = hd_val;
            phase_next        = PH_PAYLOAD;
          end
        end
        MT_ARRAY, MT_MAP: begin
          if (hd_val == '0) begin
            fin_req = 1'b1;
          end else if (open_levels >= LVL_W'(STACK_SIZE)) begin
            code = ST_TOO_DEEP;
          end else begin
            we               = (open_levels != '0);
            top_cnt_next     = hd_val;
            top_pend_next    = 1'b0;
            top_map_next     = (head_major_next == MT_MAP);
            open_levels_next = open_levels + LVL_W'(1);
          end
        end
        default: fin_req = 1'b1;
      endcase
    end

    // credit a finished item to the open container on top
    if (fin_req || cmd.step) begin
      if (open_levels == '0) begin
        code = ST_DONE;
      end else if (fin_src.is_map && !fin_src.pend_value) begin
        top_cnt_next  = fin_src.cnt;
        top_pend_next = 1'b1;
        top_map_next  = 1'b1;
      end else begin
        cnt_dec = fin_src.cnt - CNT_W'(1);
        if (cnt_dec != '0) begin
          top_cnt_next  = cnt_dec;
          top_pend_next = 1'b0;
          top_map_next  = fin_src.is_map;
        end else begin
          lvl_dec          = open_levels - LVL_W'(1);
          open_levels_next = lvl_dec;
          if (lvl_dec == '0) begin
            code = ST_DONE;
          end else begin
            cascade = 1'b1;
            re      = 1'b1;
            raddr   = ADDR_W'(lvl_dec - LVL_W'(1));
          end
        end
      end
    end

    emit       = (cmd.eval || cmd.step) && !cascade;
    final_code = (code == ST_MORE && last_r) ? ST_TRUNCATED : code;
    nest_val   = open_levels_next;
    if (emit && final_code != ST_MORE) begin
      phase_next       = PH_HEAD;
      open_levels_next = '0;
    end
  end

  assign st.out_free = !result.valid || result.ready;
  assign st.cascade  = cascade;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEAD;
      open_levels  <= '0;
      result.valid <= 1'b0;
    end else begin
      phase       <= phase_next;
      open_levels <= open_levels_next;
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= data_byte;
      last_r <= last_byte;
    end
    head_major   <= head_major_next;
    arg_left     <= arg_left_next;
    arg_value    <= arg_value_next;
    payload_left <= payload_left_next;
    top_cnt      <= top_cnt_next;
    top_pend     <= top_pend_next;
    top_map      <= top_map_next;
    if (emit) begin
      result.status        <= final_code;
      result.nesting_level <= NEST_W'(nest_val);
    end
  end

  // stack below the top entry
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (re) rd_entry <= mem[raddr];
  end

  `CISC_ASSERT(a_depth_bound, clk, rst, open_levels <= LVL_W'(STACK_SIZE), "stack overflow")
  `CISC_ASSERT(a_done_flat, clk, rst, result.valid && result.status == ST_DONE |-> result.nesting_level == '0, "done with open levels")
  `CISC_ASSERT(a_no_overwrite, clk, rst, emit |-> st.out_free, "result overwritten")
  `CISC_ASSERT_NEXT(a_emit_valid, clk, rst, emit, result.valid, "result lost")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import cisc_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int STACK_DEPTH = CISC_MAX_NEST + 1;

  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NINT   = 3'd1;
  localparam logic [2:0] MT_BSTR   = 3'd2;
  localparam logic [2:0] MT_TSTR   = 3'd3;
  localparam logic [2:0] MT_ARRAY  = 3'd4;
  localparam logic [2:0] MT_MAP    = 3'd5;
  localparam logic [2:0] MT_TAG    = 3'd6;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  localparam logic [4:0] AI_ARG8    = 5'd24;
  localparam logic [4:0] AI_ARG16   = 5'd25;
  localparam logic [4:0] AI_ARG32   = 5'd26;
  localparam logic [4:0] AI_ARG64   = 5'd27;
  localparam logic [4:0] AI_RSVD_LO = 5'd28;
  localparam logic [4:0] AI_INDEF   = 5'd31;

  typedef enum logic [1:0] {PH_HEAD, PH_ARG, PH_PAYLOAD} parse_phase_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NEST_W-1:0]   nest;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;

  cisc_in_if  bytes_if ();
  cisc_out_if result_if ();

  cbor_item_skip_checker_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .result (result_if)
  );

  always #6 clk = ~clk;

  verdict_t    expected_verdicts[$];
  logic [7:0]  pending_bytes[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          gen_depth_cap = 3;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;

  // shadow parser state
  parse_phase_e     phase = PH_HEAD;
  logic [2:0]       hd_major = '0;
  logic [3:0]       arg_left = '0;
  logic [CNT_W-1:0] hd_arg = '0;
  logic [CNT_W-1:0] str_left = '0;
  int               open_cnt = 0;
  logic [CNT_W-1:0] lvl_left[STACK_DEPTH];
  bit               lvl_map[STACK_DEPTH];
  bit               lvl_val_pending[STACK_DEPTH];

  function automatic logic [7:0] head_of(input logic [2:0] major, input logic [4:0] info);
    return {major, info};
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
  endfunction

  function automatic void clear_parser();
    phase    = PH_HEAD;
    hd_major = '0;
    arg_left = '0;
    hd_arg   = '0;
    str_left = '0;
    open_cnt = 0;
  endfunction

  // a value just ended: credit it upward, closing finished containers
  function automatic logic [STATUS_W-1:0] credit_parents();
    int top;
    while (open_cnt > 0) begin
      top = open_cnt - 1;
      if (lvl_map[top] && !lvl_val_pending[top]) begin
        lvl_val_pending[top] = 1'b1;
        return ST_MORE;
      end
      lvl_val_pending[top] = 1'b0;
      lvl_left[top] = lvl_left[top] - 1;
      if (lvl_left[top] != 0) return ST_MORE;
      open_cnt--;
    end
    return ST_DONE;
  endfunction

  function automatic logic [STATUS_W-1:0] finish_head();
    case (hd_major)
      MT_BSTR, MT_TSTR: begin
        if (hd_arg == 0) return credit_parents();
        str_left = hd_arg;
        phase = PH_PAYLOAD;
        return ST_MORE;
      end
      MT_ARRAY, MT_MAP: begin
        if (hd_arg == 0) return credit_parents();
        if (open_cnt >= STACK_DEPTH) return ST_TOO_DEEP;
        lvl_left[open_cnt] = hd_arg;
        lvl_val_pending[open_cnt] = 1'b0;
        lvl_map[open_cnt] = (hd_major == MT_MAP);
        open_cnt++;
        return ST_MORE;
      end
      default: return credit_parents();
    endcase
  endfunction

  function automatic verdict_t predict_byte(input logic [7:0] b, input logic last);
    verdict_t v;
    logic [STATUS_W-1:0] st;
    logic [4:0] info;
    st = ST_MORE;
    case (phase)
      PH_HEAD: begin
        if (open_cnt > CISC_MAX_NEST) begin
          st = ST_TOO_DEEP;
        end else begin
          info = b[4:0];
          if (info > AI_ARG64 || b[7:5] == MT_TAG) begin
            st = ST_MALFORMED;
          end else begin
            hd_major = b[7:5];
            if (info < AI_ARG8) begin
              hd_arg = CNT_W'(info);
              st = finish_head();
            end else begin
              arg_left = 4'd1 << (info - AI_ARG8);
              hd_arg = '0;
              phase = PH_ARG;
            end
          end
        end
      end
      PH_ARG: begin
        hd_arg = {hd_arg[CNT_W-9:0], b};
        if (arg_left > 0) arg_left--;
        if (arg_left == 0) begin
          phase = PH_HEAD;
          st = finish_head();
        end
      end
      default: begin
        if (str_left != 0) str_left--;
        if (str_left == 0) begin
          phase = PH_HEAD;
          st = credit_parents();
        end
      end
    endcase
    if (st == ST_MORE && last) st = ST_TRUNCATED;
    v.status = st;
    v.nest = NEST_W'(open_cnt);
    if (st != ST_MORE) clear_parser();
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      bytes_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    bytes_if.valid     <= 1'b1;
    bytes_if.data_byte <= b;
    bytes_if.last_byte <= last;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    expected_verdicts.insert(expected_verdicts.size(), predict_byte(b, last));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream(input logic mark_last);
    int n;
    n = pending_bytes.size();
    for (int i = 0; i < n; i++) send_byte(pending_bytes[i], mark_last && (i == n - 1));
    pending_bytes.delete();
  endtask

  task automatic push_fill(input logic [7:0] b, input int n);
    repeat (n) add_byte(b);
  endtask

  function automatic logic [63:0] rand_arg();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 23));
      1: return 64'($urandom_range(0, 255));
      2: return 64'($urandom_range(0, 65535));
      3: return 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // shortest encoding, sometimes one size wider
  task automatic put_head(input logic [2:0] major, input logic [63:0] val);
    int nb;
    logic [4:0] info;
    if (val < 24) nb = 0;
    else if (val < 256) nb = 1;
    else if (val < 65536) nb = 2;
    else if (val < 64'h1_0000_0000) nb = 4;
    else nb = 8;
    if (nb < 8 && $urandom_range(0, 5) == 0) nb = (nb == 0) ? 1 : nb * 2;
    case (nb)
      0: info = val[4:0];
      1: info = AI_ARG8;
      2: info = AI_ARG16;
      4: info = AI_ARG32;
      default: info = AI_ARG64;
    endcase
    add_byte(head_of(major, info));
    for (int i = nb - 1; i >= 0; i--) add_byte(val[8*i +: 8]);
  endtask

  task automatic gen_item(input int lvl);
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (lvl >= gen_depth_cap && kind >= 5 && kind <= 8) kind = $urandom_range(0, 4);
    case (kind)
      0, 1: put_head(MT_UINT, rand_arg());
      2: put_head(MT_NINT, rand_arg());
      3, 4: begin
        n = $urandom_range(0, 5);
        put_head((kind == 3) ? MT_BSTR : MT_TSTR, 64'(n));
        repeat (n) add_byte(8'($urandom));
      end
      5, 6: begin
        n = $urandom_range(0, 3);
        put_head(MT_ARRAY, 64'(n));
        repeat (n) gen_item(lvl + 1);
      end
      7, 8: begin
        n = $urandom_range(0, 2);
        put_head(MT_MAP, 64'(n));
        repeat (2 * n) gen_item(lvl + 1);
      end
      default: begin
        n = $urandom_range(0, AI_ARG64);
        add_byte(head_of(MT_SIMPLE, 5'(n)));
        if (n >= AI_ARG8) repeat (1 << (n - AI_ARG8)) add_byte(8'($urandom));
      end
    endcase
  endtask

  task automatic test_scalars();
    pending_bytes = '{head_of(MT_UINT, 5'd0)};
    send_stream(1'b1);
    pending_bytes = '{head_of(MT_UINT, 5'd23)};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_UINT, AI_ARG8), 8'hFF};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_NINT, AI_ARG16), 8'h00, 8'h00};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_UINT, AI_ARG32), 8'h12, 8'h34, 8'h56, 8'h78};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_NINT, AI_ARG64)};
    push_fill(8'hFF, 8);
    send_stream(1'b1);
    pending_bytes = '{head_of(MT_SIMPLE, 5'd20), head_of(MT_SIMPLE, AI_ARG8), 8'hFF};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_SIMPLE, AI_ARG16), 8'h7C, 8'h00};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_SIMPLE, AI_ARG32), 8'h7F, 8'h80, 8'h00, 8'h01};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_SIMPLE, AI_ARG64)};
    push_fill(8'h00, 8);
    send_stream(1'b0);
  endtask

  task automatic test_containers();
    pending_bytes = '{head_of(MT_BSTR, 5'd0), head_of(MT_TSTR, 5'd0),
                      head_of(MT_ARRAY, 5'd0), head_of(MT_MAP, 5'd0)};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_BSTR, 5'd3), 8'h00, 8'h80, 8'hFF};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_TSTR, AI_ARG8), 8'h02, 8'h68, 8'h69};
    send_stream(1'b1);
    pending_bytes = '{head_of(MT_MAP, 5'd2), head_of(MT_UINT, 5'd1), head_of(MT_ARRAY, 5'd2),
                      head_of(MT_UINT, 5'd2), head_of(MT_UINT, 5'd3), head_of(MT_TSTR, 5'd1),
                      8'h41, head_of(MT_ARRAY, 5'd0)};
    send_stream(1'b0);
    // several containers closed by one byte
    pending_bytes = '{head_of(MT_ARRAY, 5'd1), head_of(MT_ARRAY, 5'd1), head_of(MT_MAP, 5'd1),
                      head_of(MT_BSTR, 5'd0), head_of(MT_ARRAY, 5'd1), head_of(MT_UINT, 5'd5)};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_ARRAY, AI_ARG64)};
    push_fill(8'h00, 7);
    add_byte(8'h01);
    add_byte(head_of(MT_NINT, 5'd0));
    send_stream(1'b0);
  endtask

  task automatic test_malformed();
    pending_bytes = '{head_of(MT_UINT, AI_RSVD_LO), head_of(MT_NINT, 5'd29),
                      head_of(MT_BSTR, AI_INDEF), head_of(MT_TSTR, AI_INDEF),
                      head_of(MT_ARRAY, AI_INDEF), head_of(MT_MAP, AI_INDEF),
                      head_of(MT_TAG, 5'd0), head_of(MT_TAG, AI_ARG8),
                      head_of(MT_SIMPLE, 5'd30), head_of(MT_SIMPLE, AI_INDEF)};
    send_stream(1'b0);
    pending_bytes = '{head_of(MT_MAP, 5'd1), head_of(MT_UINT, 5'd1), head_of(MT_TAG, 5'd1)};
    send_stream(1'b1);
  endtask

  task automatic test_truncation();
    pending_bytes = '{head_of(MT_UINT, AI_ARG16), 8'h01};
    send_stream(1'b1);
    pending_bytes = '{head_of(MT_ARRAY, 5'd2), head_of(MT_UINT, 5'd0)};
    send_stream(1'b1);
    pending_bytes = '{head_of(MT_TSTR, 5'd4)};
    send_stream(1'b1);
    pending_bytes = '{head_of(MT_TSTR, AI_ARG64)};
    push_fill(8'hFF, 8);
    add_byte(8'h61);
    add_byte(8'h62);
    send_stream(1'b1);
    pending_bytes = '{head_of(MT_MAP, AI_ARG64)};
    push_fill(8'hFF, 8);
    add_byte(head_of(MT_UINT, 5'd0));
    add_byte(head_of(MT_UINT, 5'd1));
    send_stream(1'b1);
  endtask

  task automatic test_nesting_limit();
    push_fill(head_of(MT_ARRAY, 5'd1), CISC_MAX_NEST);
    add_byte(head_of(MT_UINT, 5'd0));
    send_stream(1'b0);
    push_fill(head_of(MT_ARRAY, 5'd1), CISC_MAX_NEST - 1);
    add_byte(head_of(MT_MAP, 5'd1));
    add_byte(head_of(MT_UINT, 5'd0));
    add_byte(head_of(MT_UINT, 5'd1));
    send_stream(1'b0);
    push_fill(head_of(MT_ARRAY, 5'd1), CISC_MAX_NEST + 1);
    add_byte(head_of(MT_UINT, 5'd0));
    send_stream(1'b0);
  endtask

  task automatic test_random_items();
    int stop_at;
    int r;
    int n;
    stop_at = bytes_sent + 170;
    while (bytes_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      gen_depth_cap = $urandom_range(1, 5);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        gen_item(0);
        send_stream(1'($urandom));
      end else if (r < 82) begin
        gen_item(0);
        n = $urandom_range(1, pending_bytes.size());
        while (pending_bytes.size() > n) void'(pending_bytes.pop_back());
        send_stream(1'b1);
      end else if (r < 84) begin
        n = $urandom_range(CISC_MAX_NEST - 4, CISC_MAX_NEST + 2);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            add_byte(head_of(MT_MAP, 5'd1));
            put_head(MT_UINT, rand_arg());
          end else begin
            add_byte(head_of(MT_ARRAY, 5'd1));
          end
        end
        gen_depth_cap = 0;
        gen_item(0);
        send_stream(1'($urandom));
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom), ($urandom_range(0, 9) == 0) || (i == n - 1));
      end
    end
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    gen_depth_cap = 3;
    repeat (8) begin
      gen_item(0);
      send_stream(1'($urandom));
    end
  endtask

  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d level %0d",
                   result_if.status, result_if.nesting_level);
      end else begin
        want = expected_verdicts.pop_front();
        if (want.status !== result_if.status || want.nest !== result_if.nesting_level) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected status %0d level %0d, got status %0d level %0d",
                     want.status, want.nest, result_if.status, result_if.nesting_level);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst                <= 1'b1;
    bytes_if.valid     <= 1'b0;
    bytes_if.data_byte <= '0;
    bytes_if.last_byte <= 1'b0;
    clear_parser();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_scalars();
    test_containers();
    test_malformed();
    test_truncation();
    test_nesting_limit();
    test_random_items();

    bytes_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (2 * CISC_MAX_NEST) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ cbor_item_skip_checker_core.f @@
+incdir+src
src/cisc_pkg.sv
src/cisc_in_if.sv
src/cisc_out_if.sv
src/cisc_ctrl.sv
src/cisc_dp.sv
src/cbor_item_skip_checker_core.sv
test/tb_top.sv
